### sv/cbi_pkg.sv
// ----------------------------------------------------------------------------
// Bicubic upscaler package
// Shared types, register indexes and constants of the Catmull-Rom upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package cbi_pkg;

  // Source store geometry and sample format.
  localparam int MAX_COLS    = 32;
  localparam int MAX_ROWS    = 32;
  localparam int MAX_SCALE   = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int COORD_BITS  = 5;
  localparam int ADDR_BITS   = 10;

  // Width of an unsaturated intermediate of a cubic pass.
  localparam int LANE_W = 22;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SRC_COLS = 2'd0,
    CFG_SRC_ROWS = 2'd1,
    CFG_SCALE    = 2'd2
  } cfg_idx_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_C1, ST_C2, ST_C3, ST_C4,
    ST_R1, ST_R2, ST_R3, ST_R4,
    ST_PUT
  } bk_state_t;

  // A classified command waiting in the queue.
  typedef struct packed {
    logic                          is_emit;
    logic [COORD_BITS-1:0]         row;
    logic [COORD_BITS-1:0]         col;
    logic [COORD_BITS-1:0]         row_max;
    logic [COORD_BITS-1:0]         col_max;
    logic [3:0]                    scale;
    logic signed [SAMPLE_BITS-1:0] sample;
  } cmd_t;

  // Step strobes of one cubic lane.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } lane_ctl_t;

  // Fractions floor(256*k/scale) in Q0.8, indexed {scale-1, k}.
  localparam logic [7:0] FRAC_TBL [64] = '{
    8'd0, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0, 8'd128, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0, 8'd85,  8'd170, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0, 8'd64,  8'd128, 8'd192, 8'd0,   8'd0,   8'd0,   8'd0,
    8'd0, 8'd51,  8'd102, 8'd153, 8'd204, 8'd0,   8'd0,   8'd0,
    8'd0, 8'd42,  8'd85,  8'd128, 8'd170, 8'd213, 8'd0,   8'd0,
    8'd0, 8'd36,  8'd73,  8'd109, 8'd146, 8'd182, 8'd219, 8'd0,
    8'd0, 8'd32,  8'd64,  8'd96,  8'd128, 8'd160, 8'd192, 8'd224
  };

endpackage

`default_nettype wire

### sv/cbi_if.sv
// ----------------------------------------------------------------------------
// Bicubic upscaler channels
// Valid/ready interfaces for the command input and the sample output.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbi_in_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [4:0]                      row;
  logic [4:0]                      col;
  logic signed [15:0]              sample;
  modport source (output valid, action, row, col, sample, input ready);
  modport sink   (input valid, action, row, col, sample, output ready);
endinterface

interface cbi_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [15:0]              out_value;
  logic [7:0]                      out_row;
  logic [7:0]                      out_col;
  logic                            last;
  modport source (output valid, out_value, out_row, out_col, last, input ready);
  modport sink   (input valid, out_value, out_row, out_col, last, output ready);
endinterface

`default_nettype wire

### sv/cbi_lane.sv
// ----------------------------------------------------------------------------
// Cubic lane
// One Catmull-Rom pass over four points in four registered steps, the last one an add and divide.
// ----------------------------------------------------------------------------
`default_nettype none

module cbi_lane (
  input  wire logic                             clk,
  input  wire cbi_pkg::lane_ctl_t               ctl,
  input  wire logic signed [cbi_pkg::LANE_W-1:0] p [4],
  input  wire logic [7:0]                       t,
  output logic signed [cbi_pkg::LANE_W-1:0]     res
);
  import cbi_pkg::*;

  logic signed [LANE_W+2:0]  a;
  logic signed [LANE_W+3:0]  b;
  logic signed [LANE_W:0]    c;
  logic signed [8:0]         ts;
  logic signed [LANE_W+11:0] m1_nxt;
  logic signed [LANE_W+12:0] acc1;
  logic signed [LANE_W+21:0] m2_nxt;
  logic signed [LANE_W+22:0] acc2;
  logic signed [LANE_W+31:0] m3_nxt;
  logic signed [LANE_W+32:0] total;
  logic signed [LANE_W+7:0]  quot;
  logic signed [LANE_W-1:0]  res_nxt;

  logic signed [LANE_W+3:0]  b_r;
  logic signed [LANE_W:0]    c_r;
  logic signed [LANE_W-1:0]  p1_r;
  logic signed [LANE_W+11:0] m1_r;
  logic signed [LANE_W+21:0] m2_r;
  logic signed [LANE_W+31:0] m3_r;
  logic signed [LANE_W-1:0]  res_r;

  // Polynomial coefficients and the Horner chain, one product per step.
  always_comb begin
    ts   = signed'({1'b0, t});
    a    = (LANE_W+3)'(p[1]) * 3 - (LANE_W+3)'(p[2]) * 3
           + (LANE_W+3)'(p[3]) - (LANE_W+3)'(p[0]);
    b    = (LANE_W+4)'(p[0]) * 2 - (LANE_W+4)'(p[1]) * 5
           + (LANE_W+4)'(p[2]) * 4 - (LANE_W+4)'(p[3]);
    c    = (LANE_W+1)'(p[2]) - (LANE_W+1)'(p[0]);
    m1_nxt = (LANE_W+12)'(a) * (LANE_W+12)'(ts);
    acc1   = ((LANE_W+13)'(b_r) <<< 8) + (LANE_W+13)'(m1_r);
    m2_nxt = (LANE_W+22)'(acc1) * (LANE_W+22)'(ts);
    acc2   = ((LANE_W+23)'(c_r) <<< 16) + (LANE_W+23)'(m2_r);
    m3_nxt = (LANE_W+32)'(acc2) * (LANE_W+32)'(ts);
  end

  // Final add and division by 2^25, truncated toward zero.
  always_comb begin
    total = ((LANE_W+33)'(p1_r) <<< 25) + (LANE_W+33)'(m3_r);
    quot  = total[LANE_W+32:25];
    if (total[LANE_W+32] && (total[24:0] != 25'd0)) begin
      quot = quot + (LANE_W+8)'(1);
    end
    res_nxt = quot[LANE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.s1) begin
      b_r  <= b;
      c_r  <= c;
      p1_r <= p[1];
      m1_r <= m1_nxt;
    end
    if (ctl.s2) begin
      m2_r <= m2_nxt;
    end
    if (ctl.s3) begin
      m3_r <= m3_nxt;
    end
    if (ctl.s4) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

### sv/cbi_front.sv
// ----------------------------------------------------------------------------
// Upscaler front end
// Holds the configuration, classifies commands and queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cbi_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  cbi_in_if.sink             in_ch,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_idx,
  input  wire logic [5:0]    cfg_wdata,
  output cbi_pkg::cmd_t      cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_pop
);
  import cbi_pkg::*;

  logic [5:0] src_cols_r;
  logic [5:0] src_rows_r;
  logic [3:0] scale_r;

  logic [COORD_BITS-1:0] col_max;
  logic [COORD_BITS-1:0] row_max;
  logic [3:0]            scale_eff;
  logic                  keep;
  logic                  push;
  cmd_t                  cmd_new;

  cmd_t       q_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cols_r <= 6'd24;
      src_rows_r <= 6'd8;
      scale_r    <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SRC_COLS: src_cols_r <= cfg_wdata;
        CFG_SRC_ROWS: src_rows_r <= cfg_wdata;
        CFG_SCALE:    scale_r    <= cfg_wdata[3:0];
        default:      ;
      endcase
    end
  end

  // Clamp the registers to their usable ranges and classify the command.
  always_comb begin
    if (src_cols_r == 6'd0) begin
      col_max = '0;
    end else if (src_cols_r > 6'(MAX_COLS)) begin
      col_max = COORD_BITS'(MAX_COLS - 1);
    end else begin
      col_max = COORD_BITS'(src_cols_r - 6'd1);
    end
    if (src_rows_r == 6'd0) begin
      row_max = '0;
    end else if (src_rows_r > 6'(MAX_ROWS)) begin
      row_max = COORD_BITS'(MAX_ROWS - 1);
    end else begin
      row_max = COORD_BITS'(src_rows_r - 6'd1);
    end
    if (scale_r == 4'd0) begin
      scale_eff = 4'd1;
    end else if (scale_r > 4'(MAX_SCALE)) begin
      scale_eff = 4'(MAX_SCALE);
    end else begin
      scale_eff = scale_r;
    end
    keep = !in_ch.action || ((in_ch.row <= row_max) && (in_ch.col <= col_max));
    cmd_new.is_emit = in_ch.action;
    cmd_new.row     = in_ch.row;
    cmd_new.col     = in_ch.col;
    cmd_new.row_max = row_max;
    cmd_new.col_max = col_max;
    cmd_new.scale   = scale_eff;
    cmd_new.sample  = in_ch.sample;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready && keep;

  // Two-entry command queue; emits outside the image are dropped here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (cmd_pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= cmd_new;
    end
  end

  assign cmd       = q_r[rptr_r];
  assign cmd_valid = (cnt_r != 2'd0);

endmodule

`default_nettype wire

### sv/cbi_back.sv
// ----------------------------------------------------------------------------
// Upscaler back end
// Pixel store, neighbourhood fetch and the interpolation sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cbi_back (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cbi_pkg::cmd_t cmd,
  input  wire logic     cmd_valid,
  output logic          cmd_pop,
  cbi_out_if.source     out_ch
);
  import cbi_pkg::*;

  bk_state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_ROWS*MAX_COLS];
  logic signed [SAMPLE_BITS-1:0] rdata_r;

  logic [COORD_BITS-1:0] row_r, col_r, row_max_r, col_max_r;
  logic [3:0]            scale_r;
  logic [7:0]            row_base_r, col_base_r;
  logic [4:0]            cnt_r;
  logic [2:0]            jk_r, ik_r;
  logic signed [LANE_W-1:0] nb_r [16];

  logic                  out_valid_r;
  logic signed [15:0]    out_value_r;
  logic [7:0]            out_row_r, out_col_r;
  logic                  last_r;

  logic                  wr_en, rd_en, put, last_col, last_row;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic signed [6:0]     rr, cc;
  logic [2:0]            s_m1;
  logic [7:0]            tc, tr, t0;
  lane_ctl_t             ctl_all, ctl_col;
  logic signed [LANE_W-1:0] lp [4][4];
  logic signed [LANE_W-1:0] lres [4];
  logic signed [15:0]    sat;

  // Combinational helpers: fractions, last flags and the output handshake.
  assign s_m1     = 3'(scale_r - 4'd1);
  assign last_col = (ik_r == s_m1);
  assign last_row = (jk_r == s_m1);
  assign tc       = FRAC_TBL[{s_m1, ik_r}];
  assign tr       = FRAC_TBL[{s_m1, jk_r}];
  assign put      = (state_r == ST_PUT) && (!out_valid_r || out_ch.ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (cmd_valid && cmd.is_emit) state_nxt = ST_FETCH;
      ST_FETCH: if (cnt_r == 5'd16) state_nxt = ST_C1;
      ST_C1:    state_nxt = ST_C2;
      ST_C2:    state_nxt = ST_C3;
      ST_C3:    state_nxt = ST_C4;
      ST_C4:    state_nxt = ST_R1;
      ST_R1:    state_nxt = ST_R2;
      ST_R2:    state_nxt = ST_R3;
      ST_R3:    state_nxt = ST_R4;
      ST_R4:    state_nxt = ST_PUT;
      ST_PUT: begin
        if (put) begin
          state_nxt = (last_col && last_row) ? ST_IDLE : ST_C1;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State outputs: queue pop, store strobes and lane step strobes.
  always_comb begin
    cmd_pop = 1'b0;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    ctl_all = '0;
    ctl_col = '0;
    t0      = tc;
    unique case (state_r)
      ST_IDLE: begin
        cmd_pop = cmd_valid;
        wr_en   = cmd_valid && !cmd.is_emit;
      end
      ST_FETCH: rd_en = (cnt_r != 5'd16);
      ST_C1: begin ctl_all.s1 = 1'b1; ctl_col.s1 = 1'b1; end
      ST_C2: begin ctl_all.s2 = 1'b1; ctl_col.s2 = 1'b1; end
      ST_C3: begin ctl_all.s3 = 1'b1; ctl_col.s3 = 1'b1; end
      ST_C4: begin ctl_all.s4 = 1'b1; ctl_col.s4 = 1'b1; end
      ST_R1: begin ctl_all.s1 = 1'b1; t0 = tr; end
      ST_R2: begin ctl_all.s2 = 1'b1; t0 = tr; end
      ST_R3: begin ctl_all.s3 = 1'b1; t0 = tr; end
      ST_R4: begin ctl_all.s4 = 1'b1; t0 = tr; end
      ST_PUT:   ;
      default:  ;
    endcase
  end

  // Clamped neighbour address for fetch step cnt (row offset high, column low).
  always_comb begin
    rr = 7'(signed'({2'b00, row_r})) + 7'(signed'({5'b0, cnt_r[3:2]})) - 7'sd1;
    cc = 7'(signed'({2'b00, col_r})) + 7'(signed'({5'b0, cnt_r[1:0]})) - 7'sd1;
    if (rr < 7'sd0) rr = 7'sd0;
    if (rr > 7'(signed'({2'b00, row_max_r}))) rr = 7'(signed'({2'b00, row_max_r}));
    if (cc < 7'sd0) cc = 7'sd0;
    if (cc > 7'(signed'({2'b00, col_max_r}))) cc = 7'(signed'({2'b00, col_max_r}));
    rd_addr = {rr[4:0], cc[4:0]};
  end

  // Single-port pixel store.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{cmd.row, cmd.col}] <= cmd.sample;
    end else if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Sequencer control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      jk_r    <= '0;
      ik_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) begin
        cnt_r <= '0;
        jk_r  <= '0;
        ik_r  <= '0;
      end else if (state_r == ST_FETCH) begin
        cnt_r <= cnt_r + 5'd1;
      end else if (put) begin
        ik_r <= last_col ? 3'd0 : ik_r + 3'd1;
        if (last_col) begin
          jk_r <= jk_r + 3'd1;
        end
      end
    end
  end

  // Command fields and neighbourhood capture.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && cmd_valid && cmd.is_emit) begin
      row_r      <= cmd.row;
      col_r      <= cmd.col;
      row_max_r  <= cmd.row_max;
      col_max_r  <= cmd.col_max;
      scale_r    <= cmd.scale;
      row_base_r <= 8'(cmd.row * cmd.scale);
      col_base_r <= 8'(cmd.col * cmd.scale);
    end
    if (state_r == ST_FETCH && cnt_r != 5'd0) begin
      nb_r[4'(cnt_r - 5'd1)] <= LANE_W'(rdata_r);
    end
  end

  // Four lanes; lane 0 also runs the pass across the row results.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int q = 0; q < 4; q++) begin
        lp[r][q] = nb_r[r*4+q];
      end
    end
    if (state_r == ST_R1) begin
      for (int q = 0; q < 4; q++) begin
        lp[0][q] = lres[q];
      end
    end
  end

  cbi_lane u_lane0 (.clk(clk), .ctl(ctl_all), .p(lp[0]), .t(t0), .res(lres[0]));
  cbi_lane u_lane1 (.clk(clk), .ctl(ctl_col), .p(lp[1]), .t(tc), .res(lres[1]));
  cbi_lane u_lane2 (.clk(clk), .ctl(ctl_col), .p(lp[2]), .t(tc), .res(lres[2]));
  cbi_lane u_lane3 (.clk(clk), .ctl(ctl_col), .p(lp[3]), .t(tc), .res(lres[3]));

  // Saturate the final pass to the sample range.
  always_comb begin
    if (lres[0] > LANE_W'(32767)) begin
      sat = 16'sh7fff;
    end else if (lres[0] < -LANE_W'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = lres[0][15:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (put) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      out_value_r <= sat;
      out_row_r   <= row_base_r + 8'(jk_r);
      out_col_r   <= col_base_r + 8'(ik_r);
      last_r      <= last_col && last_row;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.last      = last_r;

endmodule

`default_nettype wire

### sv/bicubic_image_upscaler_top.sv
// ----------------------------------------------------------------------------
// Bicubic image upscaler
// Catmull-Rom upscaler of a Q8.8 source image held in an internal store.
// ----------------------------------------------------------------------------
// Usage: a load transaction on in_ch (action 0) writes one sample into the
// 32x32 pixel store; an emit transaction (action 1) names a source cell and
// produces scale*scale interpolated samples on out_ch in row-major order,
// the final one flagged by last. Emits outside the configured image are
// dropped without output. The cfg port writes src_cols, src_rows and scale
// and is used only while the block is idle; the block does not enforce this.
// Flow: commands pass through a two-entry queue. A load is written to the
// store while the back end is idle. An emit reads its 4x4 neighbourhood
// from the single-port store, then for each output sample runs the four
// column passes on the four lanes and the row pass on the shared lane 0,
// and waits in the put state until the output register can take it.
// Reset clears control state and restores the register defaults (24 columns,
// 8 rows, scale 8); the store is undefined until written. When out_ch stalls
// the output register holds its sample and the back end waits, while the
// queue keeps accepting commands until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module bicubic_image_upscaler_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  cbi_in_if.sink          in_ch,
  cbi_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_idx,
  input  wire logic [5:0] cfg_wdata
);
  import cbi_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  cbi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  cbi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

### test/upscaler_checker.sv
// ----------------------------------------------------------------------------
// Upscaler result checker
// Watches the command and sample channels and the register port, keeps its
// own copy of the pixel store and registers, predicts every upscaled sample
// and compares it field by field with what the block produces.
// ----------------------------------------------------------------------------
`default_nettype none

module upscaler_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  cbi_in_if.sink          in_mon,
  cbi_out_if.sink         out_mon,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_idx,
  input  wire logic [5:0] cfg_wdata,
  output int              fail_count,
  output int              pending_count
);
  import cbi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] value;
    logic [7:0]         up_row;
    logic [7:0]         up_col;
    logic               last;
  } upsample_t;

  logic signed [15:0] image_copy [MAX_ROWS][MAX_COLS];
  logic [5:0]         cols_reg, rows_reg;
  logic [3:0]         scale_reg;
  upsample_t          expected_samples [$];

  assign pending_count = expected_samples.size();

  // One Catmull-Rom pass: exact product, truncated toward zero.
  function automatic longint cubic_1d(input longint p0, p1, p2, p3, input longint t);
    longint a, b, c, acc;
    a = 3 * (p1 - p2) + p3 - p0;
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c = p2 - p0;
    acc = b * 256 + a * t;
    acc = c * 65536 + acc * t;
    acc = acc * t;
    return (p1 * 64'sd33554432 + acc) / 64'sd33554432;
  endfunction

  // Queue the expected block of an emit for the cell (row, col).
  task automatic predict_block(input int row, input int col);
    int cols, rows, s, rr, cc, jk, ik, r;
    longint nbr [4][4];
    longint lane [4];
    longint v;
    upsample_t e;
    cols = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
    rows = (rows_reg == 0) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
    s = (scale_reg == 0) ? 1 : (scale_reg > MAX_SCALE) ? MAX_SCALE : scale_reg;
    if (row >= rows || col >= cols) return;
    for (int i = 0; i < 4; i++)
      for (int q = 0; q < 4; q++) begin
        rr = row + i - 1;
        cc = col + q - 1;
        if (rr < 0) rr = 0;
        if (rr > rows - 1) rr = rows - 1;
        if (cc < 0) cc = 0;
        if (cc > cols - 1) cc = cols - 1;
        nbr[i][q] = image_copy[rr][cc];
      end
    for (jk = 0; jk < s; jk++)
      for (ik = 0; ik < s; ik++) begin
        for (r = 0; r < 4; r++)
          lane[r] = cubic_1d(nbr[r][0], nbr[r][1], nbr[r][2], nbr[r][3], (ik * 256) / s);
        v = cubic_1d(lane[0], lane[1], lane[2], lane[3], (jk * 256) / s);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        e.value  = v[15:0];
        e.up_row = 8'(row * s + jk);
        e.up_col = 8'(col * s + ik);
        e.last   = (jk == s - 1) && (ik == s - 1);
        expected_samples.push_back(e);
      end
  endtask

  // Track register writes, commands and results at each rising edge.
  always @(posedge clk) begin
    upsample_t e;
    if (!rst_n) begin
      cols_reg  <= 6'd24;
      rows_reg  <= 6'd8;
      scale_reg <= 4'd8;
      expected_samples.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SRC_COLS: cols_reg <= cfg_wdata;
          CFG_SRC_ROWS: rows_reg <= cfg_wdata;
          CFG_SCALE:    scale_reg <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action) predict_block(in_mon.row, in_mon.col);
        else image_copy[in_mon.row][in_mon.col] = in_mon.sample;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected sample row %0d col %0d", out_mon.out_row, out_mon.out_col);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_samples.pop_front();
          if (out_mon.out_value !== e.value || out_mon.out_row !== e.up_row ||
              out_mon.out_col !== e.up_col || out_mon.last !== e.last) begin
            if (out_mon.out_value !== e.value)
              $error("out_value: expected %0d, got %0d", e.value, out_mon.out_value);
            if (out_mon.out_row !== e.up_row)
              $error("out_row: expected %0d, got %0d", e.up_row, out_mon.out_row);
            if (out_mon.out_col !== e.up_col)
              $error("out_col: expected %0d, got %0d", e.up_col, out_mon.out_col);
            if (out_mon.last !== e.last)
              $error("last: expected %0d, got %0d", e.last, out_mon.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

`default_nettype wire

### test/tb_bicubic_image_upscaler_top.sv
// ----------------------------------------------------------------------------
// Bicubic upscaler testbench
// Loads source images, writes the registers between phases and issues emit
// commands under varied idling on both channels; the checker predicts and
// compares every upscaled sample.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bicubic_image_upscaler_top;
  import cbi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = CFG_SRC_COLS;
  logic [5:0] cfg_wdata = '0;
  int         fail_count, pending_count;
  int         send_idle_pct = 0, recv_stall_pct = 0;
  bit         hold_off = 1'b0;
  bit         loaded [MAX_ROWS][MAX_COLS];
  logic [5:0] cur_cols = 6'd24, cur_rows = 6'd8;

  cbi_in_if  in_ch ();
  cbi_out_if out_ch ();

  bicubic_image_upscaler_top dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we, .cfg_idx, .cfg_wdata
  );

  upscaler_checker checker_i (
    .clk, .rst_n, .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_we, .cfg_idx, .cfg_wdata, .fail_count, .pending_count
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial out_ch.ready = 1'b0;
  always @(negedge clk)
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

  // Long hold-off, counted in its own process.
  task automatic long_hold();
    hold_off = 1'b1;
    repeat (2000) @(negedge clk);
    hold_off = 1'b0;
  endtask

  // Offer one command and wait for its transaction.
  task automatic send_cmd(input bit act, input int row, input int col, input int smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.action = act;
    in_ch.row    = row[4:0];
    in_ch.col    = col[4:0];
    in_ch.sample = smp[15:0];
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic load_px(input int row, input int col, input int smp);
    send_cmd(1'b0, row, col, smp);
    loaded[row][col] = 1'b1;
  endtask

  // Inside the image, emit only where the whole clamped neighbourhood is loaded.
  task automatic emit_cell(input int row, input int col);
    int rows, cols;
    rows = (cur_rows == 0) ? 1 : (cur_rows > MAX_ROWS) ? MAX_ROWS : cur_rows;
    cols = (cur_cols == 0) ? 1 : (cur_cols > MAX_COLS) ? MAX_COLS : cur_cols;
    if (row < rows && col < cols)
      for (int r = row - 1; r <= row + 2; r++)
        for (int c = col - 1; c <= col + 2; c++)
          if (!loaded[r < 0 ? 0 : r >= rows ? rows - 1 : r]
                     [c < 0 ? 0 : c >= cols ? cols - 1 : c]) return;
    send_cmd(1'b1, row, col, $urandom);
  endtask

  // Drain, then let the back end go quiet before touching the registers.
  task automatic drain();
    while (pending_count != 0) @(negedge clk);
    repeat (700) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [5:0] val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_SRC_COLS) cur_cols = val;
    if (idx == CFG_SRC_ROWS) cur_rows = val;
  endtask

  task automatic setup(input logic [5:0] c, input logic [5:0] r, input logic [5:0] s);
    drain();
    write_reg(CFG_SRC_COLS, c);
    write_reg(CFG_SRC_ROWS, r);
    write_reg(CFG_SCALE, s);
  endtask

  // Random part: mostly emits over a loaded image, some loads and stray cells.
  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1: load_px($urandom_range(31), $urandom_range(31), $urandom);
        2:    emit_cell($urandom_range(31), $urandom_range(31));
        default: emit_cell($urandom_range(7), $urandom_range(7));
      endcase
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.sample = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: fill the corner region with extremes, then emits at edges.
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++)
        load_px(r, c, (((r + c) & 1) != 0) ? -32768 : 32767);
    load_px(31, 31, 16'h5a5a);
    setup(6'd4, 6'd4, 6'd8);
    emit_cell(0, 0);
    emit_cell(3, 3);
    emit_cell(1, 2);
    emit_cell(4, 0);
    emit_cell(31, 31);
    setup(6'd1, 6'd1, 6'd1);
    emit_cell(0, 0);
    setup(6'd0, 6'd0, 6'd0);
    emit_cell(0, 0);
    setup(6'd63, 6'd40, 6'd15);
    emit_cell(0, 0);
    setup(6'd8, 6'd8, 6'd3);
    emit_cell(7, 7);
    emit_cell(2, 5);

    // Corner region with random content, then random phases under idling.
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++)
        load_px(r, c, $urandom);
    setup(6'd32, 6'd32, 6'd2);
    random_phase(60);
    send_idle_pct = 54;
    setup(6'd7, 6'd5, 6'd4);
    random_phase(60);
    send_idle_pct = 0;
    recv_stall_pct = 54;
    setup(6'd32, 6'd32, 6'd5);
    random_phase(60);
    send_idle_pct = 25;
    recv_stall_pct = 25;
    setup(6'd3, 6'd2, 6'd1);
    random_phase(60);

    // Back-pressure: hold the receiver while commands keep coming.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    setup(6'd8, 6'd8, 6'd8);
    fork
      long_hold();
      for (int i = 0; i < 5; i++) emit_cell(i, i);
    join

    drain();
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

`default_nettype wire

### filelist.f
sv/cbi_pkg.sv
sv/cbi_if.sv
sv/cbi_lane.sv
sv/cbi_front.sv
sv/cbi_back.sv
sv/bicubic_image_upscaler_top.sv
test/upscaler_checker.sv
test/tb_bicubic_image_upscaler_top.sv
